>>> src/wpm_pkg.sv
`default_nettype none

package wpm_pkg;

	// Register map: word index, byte address = 4 * index
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_WINDOW_MS      = 2'd0;
	localparam logic [1:0] REG_VOLTAGE_GAIN   = 2'd1;
	localparam logic [1:0] REG_CURRENT_GAIN   = 2'd2;
	localparam logic [1:0] REG_CURRENT_OFFSET = 2'd3;

	// Register reset values
	localparam logic [15:0] WINDOW_MS_RST      = 16'd100;
	localparam logic [19:0] VOLTAGE_GAIN_RST   = 20'd530000;
	localparam logic [19:0] CURRENT_GAIN_RST   = 20'd50000;
	localparam logic [19:0] CURRENT_OFFSET_RST = 20'd24900;

	// Result field widths and packing
	localparam int VMV_W   = 20;
	localparam int IMA_W   = 21;
	localparam int PW_W    = 41;
	localparam int TOTAL_W = 16;
	localparam int OUT_W       = VMV_W + IMA_W + PW_W + TOTAL_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

	// Saturation limits and fixed scale factors
	localparam logic [VMV_W-1:0]   VMV_MAX     = '1;
	localparam logic [IMA_W-1:0]   IMA_POS_MAX = 21'd1048575;
	localparam logic [IMA_W-1:0]   IMA_NEG_MAG = 21'd1048576;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
	localparam int                 GAIN_SHIFT  = 10;
	localparam int                 MW_DIVISOR  = 1000;

endpackage

`default_nettype wire

>>> src/windowed_power_meter.sv
`default_nettype none

// Windowed average power meter. Every accepted request adds one voltage and one
// current converter code to running sums and counts the sample; if it does not
// close the window, s_tready stays high. When the time since the window start
// exceeds window_ms, or the sample counter becomes full, the window closes on
// that sample: the block drops s_tready and works out the average voltage (mV),
// average current (mA, signed) and their product (mW) on one shared multiplier
// and one shared restoring divider that retires one quotient bit per cycle. A
// closing request runs three divisions, each over a DVD_W-bit dividend, where
// DVD_W = max(ADC_BITS+COUNT_BITS,21)+23, and may wait for the output register.
// All divisions round to nearest, halves away from zero; averages saturate to
// their field ranges. count_saturated (m_tuser) marks a window that closed only
// because the counter was full. The window then restarts at that sample's time.
// Registers (APB, word addresses): 0 window_ms, 1 voltage_gain,
// 2 current_gain, 3 current_offset.
module windowed_power_meter
	import wpm_pkg::*;
#(
	parameter int ADC_BITS = 10,
	parameter int COUNT_BITS = 16,
	localparam int IN_TDATA_W = ((2 * ADC_BITS + 32 + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input requests
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// voltage_code, current_code, time_ms (from bit 0 up), zero padded
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// results
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// avg_voltage_mv, avg_current_ma, power_mw, sample_total (from bit 0 up)
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// count_saturated
	output logic                        m_tuser,
	// configuration
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [31:0]            pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int SUM_W  = ADC_BITS + COUNT_BITS;
	localparam int MA_W   = (SUM_W > IMA_W) ? SUM_W : IMA_W;
	localparam int MB_W   = IMA_W;
	localparam int PROD_W = MA_W + MB_W;
	localparam int DVD_W  = MA_W + 23;
	localparam int DEN_W  = COUNT_BITS + GAIN_SHIFT;
	localparam int DCNT_W = $clog2(DVD_W);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_V_MUL,
		ST_I_MUL,
		ST_O_MUL,
		ST_I_SUB,
		ST_P_MUL,
		ST_LOAD,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_V,
		SEL_I,
		SEL_P
	} div_sel_t;

	state_t                  state_q;
	div_sel_t                sel_q;
	logic [15:0]             window_q;
	logic [19:0]             vgain_q;
	logic [19:0]             cgain_q;
	logic [19:0]             coff_q;
	logic [SUM_W-1:0]        vsum_q;
	logic [SUM_W-1:0]        isum_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [31:0]             wstart_q;
	logic                    sat_q;
	logic [DVD_W-1:0]        prod_q;
	logic [DVD_W-1:0]        acc_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic                    neg_q;
	logic [VMV_W-1:0]        vmv_q;
	logic [IMA_W-1:0]        imag_q;
	logic [IMA_W-1:0]        ima_q;
	logic [PW_W-1:0]         pw_q;
	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;
	logic                    out_user_q;

	logic [ADC_BITS-1:0]     vcode;
	logic [ADC_BITS-1:0]     icode;
	logic [31:0]             now;
	logic                    in_acc;
	logic [SUM_W-1:0]        vsum_nx;
	logic [SUM_W-1:0]        isum_nx;
	logic [COUNT_BITS-1:0]   count_nx;
	logic [31:0]             elapsed;
	logic                    timed;
	logic                    full;
	logic [MA_W-1:0]         mul_a;
	logic [MB_W-1:0]         mul_b;
	logic [PROD_W-1:0]       mul_p;
	logic [DVD_W-1:0]        off_term;
	logic                    sub_neg;
	logic [DVD_W-1:0]        sub_mag;
	logic [DEN_W:0]          div_shift;
	logic                    div_ge;
	logic [DEN_W:0]          div_diff;
	logic [DEN_W-1:0]        rem_nx;
	logic [DVD_W-1:0]        quo_nx;
	logic [IMA_W-1:0]        imag_sat;
	logic [31:0]             count_wide;
	logic [TOTAL_W-1:0]      total;
	logic                    out_free;
	logic                    cfg_wr;
	logic [1:0]              cfg_idx;

	// Unpack the request
	assign vcode = s_tdata[ADC_BITS-1:0];
	assign icode = s_tdata[2*ADC_BITS-1:ADC_BITS];
	assign now   = s_tdata[2*ADC_BITS+31:2*ADC_BITS];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign out_free = !out_valid_q || m_tready;

	// Accumulate and test for window close
	assign vsum_nx  = vsum_q + SUM_W'(vcode);
	assign isum_nx  = isum_q + SUM_W'(icode);
	assign count_nx = (count_q < COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign elapsed  = now - wstart_q;
	assign timed    = elapsed > 32'(window_q);
	assign full     = (count_nx == COUNT_MAX);

	// Shared multiplier operand select
	always_comb begin
		unique case (state_q)
			ST_V_MUL: begin
				mul_a = MA_W'(vsum_q);
				mul_b = MB_W'(vgain_q);
			end
			ST_I_MUL: begin
				mul_a = MA_W'(isum_q);
				mul_b = MB_W'(cgain_q);
			end
			ST_O_MUL: begin
				mul_a = MA_W'(count_q);
				mul_b = MB_W'(coff_q);
			end
			ST_P_MUL: begin
				mul_a = MA_W'(imag_q);
				mul_b = MB_W'(vmv_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// Current numerator: gain term minus offset term scaled by 1024 * n
	assign off_term = {prod_q[DVD_W-GAIN_SHIFT-1:0], {GAIN_SHIFT{1'b0}}};
	assign sub_neg  = acc_q < off_term;
	assign sub_mag  = sub_neg ? off_term - acc_q : acc_q - off_term;

	// One restoring division step
	assign div_shift = {rem_q, dvd_q[DVD_W-1]};
	assign div_diff  = div_shift - {1'b0, den_q};
	assign div_ge    = div_shift >= {1'b0, den_q};
	assign rem_nx    = div_ge ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
	assign quo_nx    = {dvd_q[DVD_W-2:0], div_ge};

	// Clamp current magnitude to the signed field range
	always_comb begin
		if (neg_q) begin
			imag_sat = (quo_nx > DVD_W'(IMA_NEG_MAG)) ? IMA_NEG_MAG : quo_nx[IMA_W-1:0];
		end else begin
			imag_sat = (quo_nx > DVD_W'(IMA_POS_MAX)) ? IMA_POS_MAX : quo_nx[IMA_W-1:0];
		end
	end

	// Sample total saturates for wide counters
	assign count_wide = 32'(count_q);
	assign total = (count_wide > 32'(TOTAL_MAX)) ? TOTAL_MAX : count_wide[TOTAL_W-1:0];

	// Sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= SEL_V;
			vsum_q      <= '0;
			isum_q      <= '0;
			count_q     <= '0;
			wstart_q    <= '0;
			sat_q       <= 1'b0;
			prod_q      <= '0;
			acc_q       <= '0;
			dvd_q       <= '0;
			den_q       <= '0;
			rem_q       <= '0;
			dcnt_q      <= '0;
			neg_q       <= 1'b0;
			vmv_q       <= '0;
			imag_q      <= '0;
			ima_q       <= '0;
			pw_q        <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= 1'b0;
		end else begin
			// Drop a taken result unless a new one is loaded in this cycle
			if (out_valid_q && m_tready && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						vsum_q  <= vsum_nx;
						isum_q  <= isum_nx;
						count_q <= count_nx;
						if (timed || full) begin
							sat_q    <= !timed;
							wstart_q <= now;
							state_q  <= ST_V_MUL;
						end
					end
				end
				ST_V_MUL: begin
					prod_q  <= DVD_W'(mul_p);
					den_q   <= {count_q, {GAIN_SHIFT{1'b0}}};
					sel_q   <= SEL_V;
					state_q <= ST_LOAD;
				end
				ST_I_MUL: begin
					prod_q  <= DVD_W'(mul_p);
					state_q <= ST_O_MUL;
				end
				ST_O_MUL: begin
					acc_q   <= prod_q;
					prod_q  <= DVD_W'(mul_p);
					state_q <= ST_I_SUB;
				end
				ST_I_SUB: begin
					prod_q  <= sub_mag;
					neg_q   <= sub_neg;
					sel_q   <= SEL_I;
					state_q <= ST_LOAD;
				end
				ST_P_MUL: begin
					prod_q  <= DVD_W'(mul_p);
					den_q   <= DEN_W'(MW_DIVISOR);
					sel_q   <= SEL_P;
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					// Add half the divisor so the floor quotient rounds
					dvd_q   <= prod_q + DVD_W'(den_q >> 1);
					rem_q   <= '0;
					dcnt_q  <= DCNT_W'(DVD_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dvd_q  <= quo_nx;
					rem_q  <= rem_nx;
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						unique case (sel_q)
							SEL_V: begin
								vmv_q <= (quo_nx > DVD_W'(VMV_MAX)) ? VMV_MAX
									: quo_nx[VMV_W-1:0];
								state_q <= ST_I_MUL;
							end
							SEL_I: begin
								imag_q  <= imag_sat;
								ima_q   <= neg_q ? -imag_sat : imag_sat;
								state_q <= ST_P_MUL;
							end
							SEL_P: begin
								pw_q    <= neg_q ? -quo_nx[PW_W-1:0] : quo_nx[PW_W-1:0];
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_EMIT: begin
					// Hold until the output register is free, then restart the window
					if (out_free) begin
						out_data_q  <= {{OUT_PAD_W{1'b0}}, total, pw_q, ima_q, vmv_q};
						out_user_q  <= sat_q;
						out_valid_q <= 1'b1;
						vsum_q      <= '0;
						isum_q      <= '0;
						count_q     <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers
	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_MS_RST;
			vgain_q  <= VOLTAGE_GAIN_RST;
			cgain_q  <= CURRENT_GAIN_RST;
			coff_q   <= CURRENT_OFFSET_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WINDOW_MS:      window_q <= pwdata[15:0];
				REG_VOLTAGE_GAIN:   vgain_q  <= pwdata[19:0];
				REG_CURRENT_GAIN:   cgain_q  <= pwdata[19:0];
				REG_CURRENT_OFFSET: coff_q   <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	// Register read back
	always_comb begin
		unique case (cfg_idx)
			REG_WINDOW_MS:      prdata = {16'b0, window_q};
			REG_VOLTAGE_GAIN:   prdata = {12'b0, vgain_q};
			REG_CURRENT_GAIN:   prdata = {12'b0, cgain_q};
			REG_CURRENT_OFFSET: prdata = {12'b0, coff_q};
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> tb/tb_windowed_power_meter.sv
`default_nettype none

module tb_windowed_power_meter;
	import wpm_pkg::*;

	localparam int CODE_W = 10;
	localparam int IN_W = ((2 * CODE_W + 32 + 7) / 8) * 8;
	// wait after the last reading; longer than a closing request takes in the block
	localparam int SETTLE = 200;
	localparam int QUIET_LIMIT = 5000;

	typedef struct {
		logic [CODE_W-1:0] vcode;
		logic [CODE_W-1:0] icode;
		logic [31:0]       stamp;
	} sample_t;

	typedef struct {
		logic [VMV_W-1:0]   vmv;
		logic [IMA_W-1:0]   ima;
		logic [PW_W-1:0]    pw;
		logic [TOTAL_W-1:0] total;
		logic               sat;
	} meter_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// voltage_code, current_code, time_ms (from bit 0 up), zero padded
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// avg_voltage_mv, avg_current_ma, power_mw, sample_total (from bit 0 up)
	logic [OUT_TDATA_W-1:0] m_tdata;
	// count_saturated
	logic m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	windowed_power_meter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Shadow registers
	logic [15:0] win_len = WINDOW_MS_RST;
	logic [19:0] vgain = VOLTAGE_GAIN_RST;
	logic [19:0] igain = CURRENT_GAIN_RST;
	logic [19:0] ioffset = CURRENT_OFFSET_RST;

	// Meter state as the block should hold it
	logic [25:0] vsum_acc = '0;
	logic [25:0] isum_acc = '0;
	logic [15:0] count_acc = '0;
	logic [31:0] win_start = '0;

	sample_t sample_backlog[$];
	meter_reading_t pending_readings[$];

	// Generator's own view of the window, used to aim at its edges
	logic [31:0] gen_start = '0;
	logic [31:0] gen_time = '0;
	int gen_count = 0;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int mismatches = 0;
	int requests_taken = 0;
	int readings_checked = 0;
	int full_windows = 0;
	int quiet_cycles = 0;

	function automatic longint div_round(longint num, longint den);
		if (num < 0)
			return -((-num + den / 2) / den);
		return (num + den / 2) / den;
	endfunction

	// Accumulate one sample and queue the reading it closes, if any
	task automatic account_sample(input logic [CODE_W-1:0] vc, input logic [CODE_W-1:0] ic,
			input logic [31:0] stamp);
		longint d, vmv, ima, pw, num;
		logic [31:0] elapsed;
		bit timed, full;
		meter_reading_t r;
		vsum_acc = vsum_acc + vc;
		isum_acc = isum_acc + ic;
		if (count_acc != '1)
			count_acc = count_acc + 1'b1;
		elapsed = stamp - win_start;
		timed = elapsed > {16'd0, win_len};
		full = (count_acc == '1);
		if (timed || full) begin
			d = longint'(count_acc) * 1024;
			vmv = div_round(longint'(vsum_acc) * longint'(vgain), d);
			if (vmv > longint'(VMV_MAX))
				vmv = longint'(VMV_MAX);
			num = longint'(isum_acc) * longint'(igain) - longint'(ioffset) * d;
			ima = div_round(num, d);
			if (ima > longint'(IMA_POS_MAX))
				ima = longint'(IMA_POS_MAX);
			if (ima < -longint'(IMA_NEG_MAG))
				ima = -longint'(IMA_NEG_MAG);
			pw = div_round(vmv * ima, MW_DIVISOR);
			r.vmv = vmv[VMV_W-1:0];
			r.ima = ima[IMA_W-1:0];
			r.pw = pw[PW_W-1:0];
			r.total = count_acc;
			r.sat = !timed && full;
			pending_readings.push_back(r);
			vsum_acc = '0;
			isum_acc = '0;
			count_acc = '0;
			win_start = stamp;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Drive requests from the backlog, predicting each one as it is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				account_sample(s_tdata[CODE_W-1:0], s_tdata[2*CODE_W-1:CODE_W],
					s_tdata[2*CODE_W +: 32]);
				requests_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (sample_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					sample_t nxt;
					nxt = sample_backlog.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_W - 2 * CODE_W - 32){1'b0}}, nxt.stamp, nxt.icode, nxt.vcode};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// Check each taken reading against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("reading with none expected, sample_total",
					m_tdata[VMV_W+IMA_W+PW_W +: TOTAL_W], 0);
			end else begin
				meter_reading_t want;
				want = pending_readings.pop_front();
				if (m_tdata[VMV_W-1:0] !== want.vmv)
					report_mismatch("avg_voltage_mv", m_tdata[VMV_W-1:0], want.vmv);
				if (m_tdata[VMV_W +: IMA_W] !== want.ima)
					report_mismatch("avg_current_ma", m_tdata[VMV_W +: IMA_W], want.ima);
				if (m_tdata[VMV_W+IMA_W +: PW_W] !== want.pw)
					report_mismatch("power_mw", m_tdata[VMV_W+IMA_W +: PW_W], want.pw);
				if (m_tdata[VMV_W+IMA_W+PW_W +: TOTAL_W] !== want.total)
					report_mismatch("sample_total", m_tdata[VMV_W+IMA_W+PW_W +: TOTAL_W],
						want.total);
				if (m_tuser !== want.sat)
					report_mismatch("count_saturated", m_tuser, want.sat);
				readings_checked++;
				if (want.sat)
					full_windows++;
			end
		end
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WINDOW_MS: win_len = value[15:0];
			REG_VOLTAGE_GAIN: vgain = value[19:0];
			REG_CURRENT_GAIN: igain = value[19:0];
			REG_CURRENT_OFFSET: ioffset = value[19:0];
			default: ;
		endcase
	endtask

	// Hold until every request is taken and every reading has come back
	task automatic wait_idle();
		@(negedge clk);
		while (sample_backlog.size() != 0 || s_tvalid || pending_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE)
			@(negedge clk);
	endtask

	task automatic push_sample(input logic [CODE_W-1:0] vc, input logic [CODE_W-1:0] ic,
			input logic [31:0] stamp);
		sample_t s;
		s.vcode = vc;
		s.icode = ic;
		s.stamp = stamp;
		sample_backlog.push_back(s);
		gen_time = stamp;
		gen_count++;
		if (stamp - gen_start > {16'd0, win_len} || gen_count == 65535) begin
			gen_start = stamp;
			gen_count = 0;
		end
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return CODE_W'($urandom_range(1023));
	endfunction

	// Random settings, then mostly steady time with probes at the window edge
	task automatic random_phase(input int count, input int src, input int snk,
			input logic [31:0] origin);
		logic [31:0] t;
		int kind;
		wait_idle();
		write_reg(REG_WINDOW_MS, {16'($urandom()), 16'($urandom_range(1, 64))});
		write_reg(REG_VOLTAGE_GAIN, $urandom());
		write_reg(REG_CURRENT_GAIN, $urandom());
		write_reg(REG_CURRENT_OFFSET, $urandom());
		@(negedge clk);
		src_idle_pct = src;
		snk_stall_pct = snk;
		push_sample(pick_code(), pick_code(), origin);
		repeat (count - 1) begin
			kind = $urandom_range(99);
			if (kind < 70)
				t = gen_time + $urandom_range(0, win_len / 3 + 1);
			else if (kind < 80)
				t = gen_start + win_len;
			else if (kind < 90)
				t = gen_start + win_len + 1;
			else if (kind < 95)
				t = $urandom();
			else
				t = gen_start - $urandom_range(1, 50);
			push_sample(pick_code(), pick_code(), t);
		end
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: first window from zero, window edge, time wrap
		@(negedge clk);
		src_idle_pct = 15;
		snk_stall_pct = 85;
		push_sample(10'd0, 10'd0, 32'd0);
		push_sample(10'd1023, 10'd1023, 32'd50);
		push_sample(10'd512, 10'd511, 32'd101);
		push_sample(10'd1023, 10'd0, 32'd201);
		push_sample(10'd0, 10'd1023, 32'd202);
		push_sample(10'd5, 10'd6, 32'hFFFF_FFF0);
		push_sample(10'd1, 10'd2, 32'hFFFF_FFFF);
		push_sample(10'd1023, 10'd1023, 32'h0000_0050);
		push_sample(10'd0, 10'd0, 32'h0000_0055);

		// One-ms window, full voltage gain, no current gain, full offset
		wait_idle();
		write_reg(REG_WINDOW_MS, 32'hFFFF_0001);
		write_reg(REG_VOLTAGE_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_CURRENT_GAIN, 32'h0000_0000);
		write_reg(REG_CURRENT_OFFSET, 32'h000F_FFFF);
		@(negedge clk);
		push_sample(10'd0, 10'd0, gen_start + 1);
		push_sample(10'd1023, 10'd1023, gen_start + 2);
		push_sample(10'd1023, 10'd0, gen_start + 1);
		push_sample(10'd0, 10'd1023, gen_start + 3);

		// Longest window, no voltage gain, current gain 0x0FFFF, no offset
		wait_idle();
		write_reg(REG_WINDOW_MS, 32'h0000_FFFF);
		write_reg(REG_VOLTAGE_GAIN, 32'h0000_0000);
		write_reg(REG_CURRENT_GAIN, 32'hFFF0_FFFF);
		write_reg(REG_CURRENT_OFFSET, 32'h0000_0000);
		@(negedge clk);
		push_sample(10'd1023, 10'd1023, gen_start + 10);
		push_sample(10'd0, 10'd0, gen_start + 32'd65535);
		push_sample(10'd1023, 10'd512, gen_start + 32'd65536);
		push_sample(10'd1, 10'd1022, gen_start + 32'hFFFF_0000);

		random_phase(430, 15, 85, $urandom());
		random_phase(430, 85, 15, $urandom());
		random_phase(440, 0, 0, 32'hFFFF_FE00);

		wait_idle();
		$display("covered %0d requests over reset, extreme and random settings;", requests_taken);
		$display("checked %0d readings, %0d closed on a full counter, %0d mismatches",
			readings_checked, full_windows, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
src/wpm_pkg.sv
src/windowed_power_meter.sv
tb/tb_windowed_power_meter.sv
